// ===== rtl/tgarle_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgarle_pkg
// Types and constants shared by the truecolor run-length image decoder.
// ----------------------------------------------------------------------------
package tgarle_pkg;

  localparam int unsigned HDR_LEN = 18;

  // header byte offsets
  localparam logic [4:0] POS_TYPE  = 5'd2;
  localparam logic [4:0] POS_W_LO  = 5'd12;
  localparam logic [4:0] POS_W_HI  = 5'd13;
  localparam logic [4:0] POS_H_LO  = 5'd14;
  localparam logic [4:0] POS_H_HI  = 5'd15;
  localparam logic [4:0] POS_DEPTH = 5'd16;
  localparam logic [4:0] POS_LAST  = 5'(HDR_LEN - 1);

  localparam logic [7:0] TYPE_RLE_MAP   = 8'd9;
  localparam logic [7:0] TYPE_RLE_TRUE  = 8'd10;
  localparam logic [7:0] DEPTH_24       = 8'd24;
  localparam logic [7:0] DEPTH_32       = 8'd32;
  localparam int unsigned RUN_FLAG_BIT  = 7;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_PIXELS = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PIXEL   = 2'd0,
    KIND_HDR_OK  = 2'd1,
    KIND_HDR_BAD = 2'd2
  } kind_t;

  // parser control state
  typedef struct packed {
    phase_t      phase;
    logic [4:0]  hpos;
    logic        run_coded;
    logic [15:0] img_w;
    logic [15:0] img_h;
    logic        four_bpp;
    logic [31:0] remaining;
    logic        pkt_run;
    logic [7:0]  pkt_left;
    logic [1:0]  bip;
  } ctl_t;

  localparam ctl_t CTL_RST = '{PH_HEADER, 5'd0, 1'b0, 16'd0, 16'd0, 1'b0,
                               32'd0, 1'b0, 8'd0, 2'd0};

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [7:0]  repeat_res;
    logic [15:0] width;
    logic [15:0] height;
    logic        has_alpha;
    logic        last_pixel;
  } res_t;

endpackage

// ===== rtl/tgarle_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgarle_step
// Next-state and result logic for one file byte: header parse, packet
// headers, pixel assembly and run clipping.
// ----------------------------------------------------------------------------
module tgarle_step (
  input  tgarle_pkg::ctl_t ctl,
  input  logic [7:0]       pb [3],
  input  logic [7:0]       file_byte,
  input  logic             start_req,
  output tgarle_pkg::ctl_t ctl_nxt,
  output logic [7:0]       pb_nxt [3],
  output logic             emit,
  output tgarle_pkg::res_t res
);

  tgarle_pkg::ctl_t cur;
  logic             hdr_ok;
  logic [1:0]       last_idx;
  logic [7:0]       rep;

  always_comb begin
    cur      = start_req ? tgarle_pkg::CTL_RST : ctl;
    ctl_nxt  = cur;
    pb_nxt   = pb;
    emit     = 1'b0;
    res      = '0;
    hdr_ok   = (cur.img_w != 16'd0) && (cur.img_h != 16'd0) &&
               ((file_byte == tgarle_pkg::DEPTH_24) || (file_byte == tgarle_pkg::DEPTH_32));
    last_idx = cur.four_bpp ? 2'd3 : 2'd2;
    rep      = 8'd1;

    unique case (cur.phase)
      tgarle_pkg::PH_HEADER: begin
        if (cur.hpos < tgarle_pkg::POS_LAST) ctl_nxt.hpos = cur.hpos + 5'd1;
        unique case (cur.hpos)
          tgarle_pkg::POS_TYPE: begin
            ctl_nxt.run_coded = (file_byte == tgarle_pkg::TYPE_RLE_MAP) ||
                                (file_byte == tgarle_pkg::TYPE_RLE_TRUE);
          end
          tgarle_pkg::POS_W_LO: ctl_nxt.img_w[7:0]  = file_byte;
          tgarle_pkg::POS_W_HI: ctl_nxt.img_w[15:8] = file_byte;
          tgarle_pkg::POS_H_LO: ctl_nxt.img_h[7:0]  = file_byte;
          tgarle_pkg::POS_H_HI: ctl_nxt.img_h[15:8] = file_byte;
          tgarle_pkg::POS_DEPTH: begin
            ctl_nxt.four_bpp = (file_byte == tgarle_pkg::DEPTH_32);
            emit             = 1'b1;
            res.kind         = hdr_ok ? tgarle_pkg::KIND_HDR_OK : tgarle_pkg::KIND_HDR_BAD;
            res.width        = cur.img_w;
            res.height       = cur.img_h;
            res.has_alpha    = (file_byte == tgarle_pkg::DEPTH_32);
            if (hdr_ok) begin
              ctl_nxt.remaining = {16'd0, cur.img_w} * {16'd0, cur.img_h};
            end else begin
              ctl_nxt.phase = tgarle_pkg::PH_DONE;
            end
          end
          tgarle_pkg::POS_LAST: begin
            ctl_nxt.phase    = tgarle_pkg::PH_PIXELS;
            ctl_nxt.pkt_left = 8'd0;
            ctl_nxt.pkt_run  = 1'b0;
            ctl_nxt.bip      = 2'd0;
          end
          default: ;
        endcase
      end
      tgarle_pkg::PH_PIXELS: begin
        if (cur.remaining == 32'd0) begin
          ctl_nxt.phase = tgarle_pkg::PH_DONE;
        end else if (cur.run_coded && (cur.pkt_left == 8'd0) && (cur.bip == 2'd0)) begin
          // packet header byte
          ctl_nxt.pkt_run  = file_byte[tgarle_pkg::RUN_FLAG_BIT];
          ctl_nxt.pkt_left = {1'b0, file_byte[6:0]} + 8'd1;
        end else if (cur.bip < last_idx) begin
          pb_nxt[cur.bip] = file_byte;
          ctl_nxt.bip     = cur.bip + 2'd1;
        end else begin
          ctl_nxt.bip = 2'd0;
          if (cur.run_coded && cur.pkt_run) begin
            // clip the run to the pixels still owed
            rep = ({24'd0, cur.pkt_left} > cur.remaining) ? cur.remaining[7:0]
                                                            : cur.pkt_left;
            ctl_nxt.pkt_left = 8'd0;
          end else if (cur.run_coded && (cur.pkt_left != 8'd0)) begin
            ctl_nxt.pkt_left = cur.pkt_left - 8'd1;
          end
          ctl_nxt.remaining = cur.remaining - {24'd0, rep};
          emit            = 1'b1;
          res.kind        = tgarle_pkg::KIND_PIXEL;
          res.red         = cur.four_bpp ? pb[2] : file_byte;
          res.alpha       = cur.four_bpp ? file_byte : 8'd0;
          res.green       = pb[1];
          res.blue        = pb[0];
          res.repeat_res  = rep;
          res.has_alpha   = cur.four_bpp;
          res.last_pixel  = (ctl_nxt.remaining == 32'd0);
          if (ctl_nxt.remaining == 32'd0) ctl_nxt.phase = tgarle_pkg::PH_DONE;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/tga_rle_pixel_decoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder_core
// Byte-stream decoder for truecolor (24/32-bit) image files, raw or
// run-length coded, emitting a header word and RGB(A) pixel words.
// ----------------------------------------------------------------------------
// Takes one file byte per clock with no gaps required while the output is not
// stalled; each byte goes through an input register and one pass of decode
// logic into the result register, which presents its result word. The rate is
// set by the single decode pass, whose longest path is the width by height
// product taken on the depth byte. A header word comes out on header byte 16,
// one pixel word per pixel (a run packet gives one word carrying its repeat
// count), and start on in_tuser restarts the parser at that byte.
module tga_rle_pixel_decoder_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] file_byte
  input  logic [0:0]  in_tuser,   // [0] start_req
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha,
  // [39:32] repeat_res, [55:40] width, [71:56] height
  output logic [71:0] out_tdata,
  output logic [2:0]  out_tuser,  // [1:0] kind, [2] has_alpha
  output logic        out_tlast   // last_pixel
);

  logic             s1_valid_r;
  logic [7:0]       s1_byte_r;
  logic             s1_start_r;
  logic             adv;

  tgarle_pkg::ctl_t ctl_r, ctl_nxt;
  logic [7:0]       pb_r [3];
  logic [7:0]       pb_nxt [3];
  logic             emit;
  tgarle_pkg::res_t res_nxt, res_r;
  logic             out_valid_r;

  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;

  tgarle_step u_step (
    .ctl       (ctl_r),
    .pb        (pb_r),
    .file_byte (s1_byte_r),
    .start_req (s1_start_r),
    .ctl_nxt   (ctl_nxt),
    .pb_nxt    (pb_nxt),
    .emit      (emit),
    .res       (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r  <= in_tdata;
      s1_start_r <= in_tuser[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= tgarle_pkg::CTL_RST;
    end else if (adv) begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pb_r <= pb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= emit;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {res_r.height, res_r.width, res_r.repeat_res, res_r.alpha,
                       res_r.blue, res_r.green, res_r.red};
  assign out_tuser  = {res_r.has_alpha, res_r.kind};
  assign out_tlast  = res_r.last_pixel;

  // pixel phase always owes at least one pixel
  a_pix_owed: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_r.phase == tgarle_pkg::PH_PIXELS) |-> (ctl_r.remaining != 32'd0))
    else $error("pixel phase with nothing owed");

  // a pixel word stands for at least one pixel
  a_rep_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (res_r.kind == tgarle_pkg::KIND_PIXEL)) |-> (res_r.repeat_res != 8'd0))
    else $error("pixel word with zero repeat");

  // header words carry no pixel count and never close the image
  a_hdr_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (res_r.kind != tgarle_pkg::KIND_PIXEL)) |->
      ((res_r.repeat_res == 8'd0) && !res_r.last_pixel))
    else $error("header word with pixel fields set");

  // last pixel leaves the parser done
  a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && emit && res_nxt.last_pixel && !in_tvalid) |=>
      (ctl_r.phase == tgarle_pkg::PH_DONE))
    else $error("parser not done after last pixel");

endmodule
